// ----- rtl/lmtf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmtf_pkg: shared types for the LRU move-to-front list
// Command and status groups between controller and datapath, fixed widths.
// ----------------------------------------------------------------------------
package lmtf_pkg;

	// fixed widths of the capacity write data and the occupancy field
	localparam int CAP_BITS = 5;
	localparam int OCC_BITS = 5;

	// func codes carried on s_tuser
	localparam logic FUNC_ACCESS = 1'b0;
	localparam logic FUNC_DUMP   = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the input transfer
		logic step;   // perform one access, or emit one dump entry
	} lmtf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
		logic done;      // the current step is the final one for this item
	} lmtf_sts_t;

endpackage

// ----- rtl/lru_move_to_front_list.sv -----
// ----------------------------------------------------------------------------
// lru_move_to_front_list: LRU recency list with move-to-front
// Holds up to capacity keys in recency order, reports hits and evictions,
// and dumps the held keys from least to most recent on request.
// ----------------------------------------------------------------------------
// An access takes the transfer, then does the parallel compare of all held
// keys and the move-to-front shift, after which the next item is taken. A
// dump takes the transfer and then emits one held key per step (a single
// step when empty), set by the single read port on the key registers;
// both stretch while the result register is held by m_tready low. Keys are held
// in flip-flops with no reset; the occupancy count clears at reset, so no
// clearing pass is needed. The user is to write capacity on cfg_wen only while
// idle; the block does not enforce it. Zero acts as one, above DEPTH as DEPTH.
module lru_move_to_front_list #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config
	input  logic                                cfg_wen,
	input  logic [lmtf_pkg::CAP_BITS-1:0]       cfg_wdata,   // capacity
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((KEY_BITS+7)/8)*8-1:0]       s_tdata,     // key
	input  logic                                s_tuser,     // func
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// entry_key, entry_valid, hit, evicted, evicted_key, occupancy
	output logic [((2*KEY_BITS+8+7)/8)*8-1:0]   m_tdata,
	output logic                                m_tuser,     // is_listing
	output logic                                m_tlast      // last
);

	lmtf_pkg::lmtf_cmd_t cmd;
	lmtf_pkg::lmtf_sts_t sts;

	lmtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lmtf_datapath #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_func   (s_tuser),
		.in_key    (s_tdata[KEY_BITS-1:0]),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// a step is only issued when the result register can take it
	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.out_free)
		else $error("step issued with result register full");

	// one item at a time: no transfer taken right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while item still in progress");

	// an access gives a single result
	a_access_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("access result without last");

	// hit and eviction are exclusive
	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[KEY_BITS+1] && m_tdata[KEY_BITS+2]))
		else $error("hit and eviction in one result");

endmodule

// ----- rtl/lmtf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmtf_ctrl: sequencing for the LRU move-to-front list
// Takes one input item at a time and steps the datapath until it is finished.
// ----------------------------------------------------------------------------
module lmtf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lmtf_pkg::lmtf_sts_t sts,
	output lmtf_pkg::lmtf_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q, state_nxt;

	// command decode
	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.step = (state_q == S_RUN) && sts.out_free;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) state_nxt = S_RUN;
			end
			S_RUN: begin
				if (cmd.step && sts.done) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/lmtf_datapath.sv -----
// ----------------------------------------------------------------------------
// lmtf_datapath: key store, compare, shift and result register
// Keys sit in registers, most recent at position 0; compare is parallel.
// ----------------------------------------------------------------------------
module lmtf_datapath #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lmtf_pkg::lmtf_cmd_t                     cmd,
	output lmtf_pkg::lmtf_sts_t                     sts,
	input  logic                                    in_func,
	input  logic [KEY_BITS-1:0]                     in_key,
	input  logic                                    cfg_wen,
	input  logic [lmtf_pkg::CAP_BITS-1:0]           cfg_wdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((2*KEY_BITS+8+7)/8)*8-1:0]       m_tdata,
	output logic                                    m_tuser,
	output logic                                    m_tlast
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int TW = ((2*KEY_BITS + 8 + 7) / 8) * 8;

	logic [KEY_BITS-1:0] keys_q [DEPTH];
	logic [KEY_BITS-1:0] key_q;
	logic                func_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       cap_q;
	logic [IW-1:0]       idx_q;

	logic                hit;
	logic [IW-1:0]       hit_idx;
	logic                full;
	logic [IW-1:0]       pos;
	logic [IW-1:0]       rd_addr;
	logic [KEY_BITS-1:0] rd_key;
	logic [CW-1:0]       count_nxt;
	logic [CW-1:0]       cap_new;
	logic                dump_end;

	// result register
	logic                         valid_q;
	logic                         listing_q;
	logic [KEY_BITS-1:0]          ekey_q;
	logic                         evalid_q;
	logic                         hit_q;
	logic                         evf_q;
	logic [KEY_BITS-1:0]          evkey_q;
	logic [lmtf_pkg::OCC_BITS-1:0] occ_q;
	logic                         last_q;

	// parallel compare over held entries; keys are unique so an OR encodes
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if ((CW'(i) < count_q) && (keys_q[i] == key_q)) begin
				hit     = 1'b1;
				hit_idx = hit_idx | IW'(i);
			end
		end
	end

	// insertion point and single read port (victim or dump entry)
	always_comb begin
		full = (count_q >= cap_q);
		if (hit) begin
			pos = hit_idx;
		end else if (full) begin
			pos = IW'(count_q - CW'(1));
		end else begin
			pos = IW'(count_q);
		end
		rd_addr   = func_q ? idx_q : pos;
		rd_key    = keys_q[rd_addr];
		count_nxt = (!hit && !full) ? CW'(count_q + CW'(1)) : count_q;
		dump_end  = (count_q == '0) || (idx_q == '0);
	end

	// capacity clamp: zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new = CW'(1);
		end else if (32'(cfg_wdata) > DEPTH) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cfg_wdata);
		end
	end

	always_comb begin
		sts.out_free = !valid_q || m_tready;
		sts.done     = (func_q == lmtf_pkg::FUNC_ACCESS) || dump_end;
	end

	// key shift line: move-to-front on access
	always_ff @(posedge clk) begin
		if (cmd.step && (func_q == lmtf_pkg::FUNC_ACCESS)) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (i == 0) begin
					keys_q[0] <= key_q;
				end else if (IW'(i) <= pos) begin
					keys_q[i] <= keys_q[i-1];
				end
			end
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
		end
	end

	// control registers: func, count, capacity, dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q  <= lmtf_pkg::FUNC_ACCESS;
			count_q <= '0;
			cap_q   <= CW'(DEPTH);
			idx_q   <= '0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cap_new;
				if (count_q > cap_new) count_q <= cap_new;
			end
			if (cmd.load) begin
				func_q <= in_func;
				idx_q  <= IW'(count_q - CW'(1));
			end
			if (cmd.step) begin
				if (func_q == lmtf_pkg::FUNC_ACCESS) begin
					count_q <= count_nxt;
				end else begin
					idx_q <= IW'(idx_q - IW'(1));
				end
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.step) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (func_q == lmtf_pkg::FUNC_DUMP) begin
				listing_q <= 1'b1;
				ekey_q    <= (count_q != '0) ? rd_key : '0;
				evalid_q  <= (count_q != '0);
				hit_q     <= 1'b0;
				evf_q     <= 1'b0;
				evkey_q   <= '0;
				occ_q     <= lmtf_pkg::OCC_BITS'(count_q);
				last_q    <= dump_end;
			end else begin
				listing_q <= 1'b0;
				ekey_q    <= '0;
				evalid_q  <= 1'b0;
				hit_q     <= hit;
				evf_q     <= !hit && full;
				evkey_q   <= (!hit && full) ? rd_key : '0;
				occ_q     <= lmtf_pkg::OCC_BITS'(count_nxt);
				last_q    <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = listing_q;
	assign m_tlast  = last_q;
	assign m_tdata  = TW'({occ_q, evkey_q, evf_q, hit_q, evalid_q, ekey_q});

endmodule
